FILE: rtl/trf_pkg.sv
// trf_pkg: shared codes, field widths and the controller command type
// for the token ring fifo with peek. no dependencies.
`default_nettype none

package trf_pkg;

	localparam int TOKEN_W = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 4;
	localparam int CAP_W = 4;
	localparam int IN_USER_W = ACTION_W + 1;
	localparam int OUT_DATA_W = TOKEN_W + 2 * COUNT_W;

	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// command from the controller to the datapath
	typedef struct packed {
		logic take;
	} trf_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/trf_ctrl.sv
// trf_ctrl: handshake controller, tracks whether the result register holds
// an undelivered result. depends on trf_pkg.
`default_nettype none

module trf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output trf_pkg::trf_cmd_t    cmd
);

	localparam logic OUT_EMPTY = 1'b0;
	localparam logic OUT_FULL = 1'b1;

	logic state_q;
	logic state_d;

	assign s_tready = (state_q == OUT_EMPTY) || m_tready;
	assign m_tvalid = (state_q == OUT_FULL);
	assign cmd.take = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			OUT_EMPTY: begin
				if (cmd.take) state_d = OUT_FULL;
			end
			OUT_FULL: begin
				if (cmd.take) state_d = OUT_FULL;
				else if (m_tready) state_d = OUT_EMPTY;
			end
			default: state_d = OUT_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OUT_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// a taken transaction always shows up as a result next cycle
	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> m_tvalid)
		else $error("taken item produced no result");

	// a stalled result blocks new input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted over a stalled result");

	// an empty result register never refuses input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("idle block not ready");

endmodule

`default_nettype wire

FILE: rtl/trf_dpath.sv
// trf_dpath: ring pointers, peek cursor, token memory and result register.
// depends on trf_pkg; driven by commands from trf_ctrl.
`default_nettype none

module trf_dpath #(
	parameter int RING_SLOTS = 16,
	parameter int TOKEN_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire trf_pkg::trf_cmd_t                 cmd,
	input  wire logic [trf_pkg::ACTION_W-1:0]      action,
	input  wire logic [trf_pkg::TOKEN_W-1:0]       token,
	input  wire logic                              peek_end,
	input  wire logic                              cfg_we,
	input  wire logic [trf_pkg::CAP_W-1:0]         cfg_wdata,
	output logic [trf_pkg::TOKEN_W-1:0]            data,
	output logic [trf_pkg::STATUS_W-1:0]           status,
	output logic [trf_pkg::COUNT_W-1:0]            level,
	output logic [trf_pkg::COUNT_W-1:0]            space
);

	localparam int IW = $clog2(RING_SLOTS);
	localparam int CW = IW + 1;
	localparam int LW = (IW > trf_pkg::CAP_W) ? IW : trf_pkg::CAP_W;
	localparam int MAX_LAST = RING_SLOTS - 1;
	localparam int RST_LAST = (MAX_LAST < 15) ? MAX_LAST : 15;

	logic [TOKEN_BITS-1:0] mem [RING_SLOTS];

	logic [IW-1:0] rd_q, wr_q, pk_q, last_q;
	logic [IW-1:0] rd_d, wr_d, pk_d;
	logic [IW-1:0] rd_adv, wr_adv, pk_adv;
	logic [IW-1:0] mem_addr;
	logic          mem_we, mem_re;
	logic [trf_pkg::STATUS_W-1:0] status_d;
	logic [CW-1:0] diff, lvl_full;
	logic [trf_pkg::CAP_W-1:0] cap_eff;
	logic [LW-1:0] cap_ext;
	logic [IW-1:0] last_new;

	logic [trf_pkg::TOKEN_W-1:0]  data_q;
	logic [trf_pkg::STATUS_W-1:0] status_q;
	logic [trf_pkg::COUNT_W-1:0]  level_q, space_q;

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
		input logic [IW-1:0] last);
		logic [IW-1:0] n;
		if (idx == last) n = '0;
		else n = idx + 1'b1;
		return n;
	endfunction

	// zero capacity acts as one, and the ring never outgrows the storage
	always_comb begin
		cap_eff = (cfg_wdata == '0) ? trf_pkg::CAP_W'(1) : cfg_wdata;
		cap_ext = LW'(cap_eff);
		if (cap_ext > LW'(MAX_LAST)) last_new = IW'(MAX_LAST);
		else last_new = IW'(cap_ext);
	end

	assign rd_adv = advance(rd_q, last_q);
	assign wr_adv = advance(wr_q, last_q);
	assign pk_adv = advance(pk_q, last_q);

	always_comb begin
		rd_d = rd_q;
		wr_d = wr_q;
		pk_d = pk_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = rd_q;
		status_d = trf_pkg::ST_DONE;
		case (action)
			trf_pkg::ACT_WRITE: begin
				if (wr_adv == rd_q) begin
					status_d = trf_pkg::ST_FULL;
				end else begin
					mem_we = 1'b1;
					wr_d = wr_adv;
				end
			end
			trf_pkg::ACT_READ: begin
				if (rd_q == wr_q) begin
					status_d = trf_pkg::ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					rd_d = rd_adv;
					// cursor sitting on the consumed slot moves along with it
					if (pk_q == rd_q) pk_d = rd_adv;
				end
			end
			trf_pkg::ACT_PEEK: begin
				if (pk_q == wr_q) begin
					status_d = trf_pkg::ST_EMPTY;
					pk_d = rd_q;
				end else begin
					mem_re = 1'b1;
					mem_addr = pk_q;
					pk_d = peek_end ? rd_q : pk_adv;
				end
			end
			default: begin
				status_d = trf_pkg::ST_DONE;
			end
		endcase
	end

	// fill level after this transaction, modulo the ring length
	always_comb begin
		diff = {1'b0, wr_d} - {1'b0, rd_d};
		if (wr_d >= rd_d) lvl_full = diff;
		else lvl_full = diff + CW'(last_q) + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			pk_q <= '0;
			last_q <= IW'(RST_LAST);
		end else if (cfg_we) begin
			rd_q <= '0;
			wr_q <= '0;
			pk_q <= '0;
			last_q <= last_new;
		end else if (cmd.take) begin
			rd_q <= rd_d;
			wr_q <= wr_d;
			pk_q <= pk_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mem_we) mem[wr_q] <= TOKEN_BITS'(token);
		if (cmd.take) begin
			data_q <= mem_re ? trf_pkg::TOKEN_W'(mem[mem_addr]) : '0;
			status_q <= status_d;
			level_q <= trf_pkg::COUNT_W'(lvl_full);
			space_q <= trf_pkg::COUNT_W'(CW'(last_q) - lvl_full);
		end
	end

	assign data = data_q;
	assign status = status_q;
	assign level = level_q;
	assign space = space_q;

endmodule

`default_nettype wire

FILE: rtl/token_ring_fifo_with_peek.sv
// token_ring_fifo_with_peek: top level, joins the handshake controller and
// the ring datapath. depends on trf_pkg, trf_ctrl and trf_dpath.
//
// a token fifo over a ring of capacity+1 slots (one always left empty), with
// a separate peek cursor. each input transaction is a write, read, peek or
// status query and yields exactly one result with a status code and the
// level and free space left afterwards. a new transaction is taken every
// clock as long as the result register is empty or being drained, so the
// block sustains one item per cycle; the result is registered and appears in
// the cycle after the transaction is taken. refused accesses (full write,
// empty read, exhausted peek) return a status and no data. writing capacity
// clears all pointers and must happen idle.
`default_nettype none

module token_ring_fifo_with_peek #(
	parameter int RING_SLOTS = 16,
	parameter int TOKEN_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [trf_pkg::TOKEN_W-1:0]         s_tdata,  // token
	input  wire logic [trf_pkg::IN_USER_W-1:0]       s_tuser,  // action, peek_end
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [trf_pkg::OUT_DATA_W-1:0]           m_tdata,  // data, level, space
	output logic [trf_pkg::STATUS_W-1:0]             m_tuser,  // status
	input  wire logic                                cfg_we,
	input  wire logic [trf_pkg::CAP_W-1:0]           cfg_wdata
);

	trf_pkg::trf_cmd_t cmd;
	logic [trf_pkg::TOKEN_W-1:0] data;
	logic [trf_pkg::COUNT_W-1:0] level, space;

	trf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	trf_dpath #(
		.RING_SLOTS (RING_SLOTS),
		.TOKEN_BITS (TOKEN_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (s_tuser[trf_pkg::ACTION_W-1:0]),
		.token     (s_tdata),
		.peek_end  (s_tuser[trf_pkg::ACTION_W]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.data      (data),
		.status    (m_tuser),
		.level     (level),
		.space     (space)
	);

	assign m_tdata = {space, level, data};

endmodule

`default_nettype wire
